FILE: hdl/spct_pkg.sv
// Shared types and widths for the shape pair collision test.
// Used by spct_sq, shape_pair_collision_test and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spct_pkg;

  // Field widths of the input item
  localparam int POS_W  = 24;  // signed Q16.8 position
  localparam int SIZE_W = 23;  // unsigned Q15.8 size

  // Internal widths
  localparam int ABS_W  = 25;  // |dx|, below 2^24
  localparam int SUM_W  = 24;  // sum of two sizes
  localparam int DIFF_W = 27;  // signed 2|dx| - w
  localparam int SQ_W   = 50;  // square of an ABS_W operand
  localparam int ACC_W  = 51;  // sum of two squares

  // Pair kind
  typedef enum logic [1:0] {
    MODE_RR,  // rectangle / rectangle
    MODE_RC,  // rectangle / circle, either order
    MODE_CC   // circle / circle
  } mode_t;

  // Per-item decision flags carried alongside the squares
  typedef struct packed {
    mode_t mode;
    logic  rr_hit;    // rectangle pair overlaps
    logic  rc_miss;   // mixed pair: a doubled gap exceeds the doubled radius
    logic  rc_early;  // mixed pair: circle center inside one slab
  } ctl_t;

  // Multiplier operands, each squared
  typedef struct packed {
    logic [ABS_W-1:0] a;
    logic [ABS_W-1:0] b;
    logic [ABS_W-1:0] c;
  } sq_ops_t;

endpackage

`default_nettype wire

FILE: hdl/spct_sq.sv
// Squaring stage of the shape pair collision test: three registered squares.
// Depends on spct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spct_sq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   valid_i,
  input  wire spct_pkg::sq_ops_t      ops_i,
  input  wire spct_pkg::ctl_t         ctl_i,
  output logic                        valid_o,
  output logic [spct_pkg::SQ_W-1:0]   sq_a_o,
  output logic [spct_pkg::SQ_W-1:0]   sq_b_o,
  output logic [spct_pkg::SQ_W-1:0]   sq_c_o,
  output spct_pkg::ctl_t              ctl_o
);

  localparam int PAD_W = spct_pkg::SQ_W - spct_pkg::ABS_W;

  logic                      valid_r;
  logic [spct_pkg::SQ_W-1:0] sq_a_r, sq_b_r, sq_c_r;
  logic [spct_pkg::SQ_W-1:0] sq_a_nxt, sq_b_nxt, sq_c_nxt;
  spct_pkg::ctl_t            ctl_r;

  // One 25x25 multiply per operand; upper operand bits are zero
  always_comb begin
    sq_a_nxt = {{PAD_W{1'b0}}, ops_i.a} * {{PAD_W{1'b0}}, ops_i.a};
    sq_b_nxt = {{PAD_W{1'b0}}, ops_i.b} * {{PAD_W{1'b0}}, ops_i.b};
    sq_c_nxt = {{PAD_W{1'b0}}, ops_i.c} * {{PAD_W{1'b0}}, ops_i.c};
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      sq_a_r <= sq_a_nxt;
      sq_b_r <= sq_b_nxt;
      sq_c_r <= sq_c_nxt;
      ctl_r  <= ctl_i;
    end
  end

  assign valid_o = valid_r;
  assign sq_a_o  = sq_a_r;
  assign sq_b_o  = sq_b_r;
  assign sq_c_o  = sq_c_r;
  assign ctl_o   = ctl_r;

endmodule

`default_nettype wire

FILE: hdl/shape_pair_collision_test.sv
// Top level of the shape pair collision test: four-stage overlap pipeline.
// Depends on spct_pkg and spct_sq.
`timescale 1ns / 1ps
`default_nettype none

// Tests one pair of 2-D shapes (axis-aligned rectangle or circle) per transfer
// and returns one transfer whose bit 0 says whether they overlap. A pair passes
// through its stages in order (difference and absolute value, interval compares
// and operand select, squaring, sum and compare), and a new pair is taken in
// every cycle unless a stalled output holds a full pipeline. Each stage advances
// when the stage after it is empty or moving, so bubbles close up and a stalled
// output only holds the pipeline once every stage is full. The result register
// is the last stage. All comparisons are exact; no division or rounding occurs.
module shape_pair_collision_test (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, lowest bit up: a_x[23:0], a_y[47:24], a_w[70:48], a_h[93:71],
  // b_x[117:94], b_y[141:118], b_w[164:142], b_h[187:165], zero pad [191:188]
  input  wire logic [191:0] in_tdata,
  // in_tuser, lowest bit up: a_is_circle, b_is_circle
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tdata, lowest bit up: hit, zero pad [7:1]
  output logic [7:0]        out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready
);

  // Unpacked input fields
  logic                                a_is_circle, b_is_circle;
  logic signed [spct_pkg::POS_W-1:0]   a_x, a_y, b_x, b_y;
  logic [spct_pkg::SIZE_W-1:0]         a_w, a_h, b_w, b_h;

  assign a_is_circle = in_tuser[0];
  assign b_is_circle = in_tuser[1];
  assign a_x = in_tdata[23:0];
  assign a_y = in_tdata[47:24];
  assign a_w = in_tdata[70:48];
  assign a_h = in_tdata[93:71];
  assign b_x = in_tdata[117:94];
  assign b_y = in_tdata[141:118];
  assign b_w = in_tdata[164:142];
  assign b_h = in_tdata[187:165];

  // Stage enables
  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3, v4_r;

  assign en4       = !v4_r || out_tready;
  assign en3       = !v3 || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  // ---------------- Stage 1: differences, sizes, pair kind ----------------
  logic signed [spct_pkg::ABS_W-1:0] dx, dy;
  logic [spct_pkg::ABS_W-1:0]        absx_nxt, absy_nxt;
  spct_pkg::mode_t                   mode_nxt;
  logic [spct_pkg::SUM_W-1:0]        wsum_nxt, hsum_nxt, rsum_nxt;
  logic [spct_pkg::SIZE_W-1:0]       rw_nxt, rh_nxt, r_nxt;

  logic [spct_pkg::ABS_W-1:0]        absx_r, absy_r;
  spct_pkg::mode_t                   mode1_r;
  logic [spct_pkg::SUM_W-1:0]        wsum_r, hsum_r, rsum_r;
  logic [spct_pkg::SIZE_W-1:0]       rw_r, rh_r, r_r;

  always_comb begin
    dx = $signed({b_x[spct_pkg::POS_W-1], b_x}) - $signed({a_x[spct_pkg::POS_W-1], a_x});
    dy = $signed({b_y[spct_pkg::POS_W-1], b_y}) - $signed({a_y[spct_pkg::POS_W-1], a_y});
    absx_nxt = dx[spct_pkg::ABS_W-1] ? spct_pkg::ABS_W'(-dx) : spct_pkg::ABS_W'(dx);
    absy_nxt = dy[spct_pkg::ABS_W-1] ? spct_pkg::ABS_W'(-dy) : spct_pkg::ABS_W'(dy);
    wsum_nxt = {1'b0, a_w} + {1'b0, b_w};
    hsum_nxt = {1'b0, a_h} + {1'b0, b_h};
    rsum_nxt = wsum_nxt;
    // Mixed pair: pick out the rectangle and the radius
    rw_nxt   = a_is_circle ? b_w : a_w;
    rh_nxt   = a_is_circle ? b_h : a_h;
    r_nxt    = a_is_circle ? a_w : b_w;
    unique case ({b_is_circle, a_is_circle})
      2'b00:   mode_nxt = spct_pkg::MODE_RR;
      2'b01:   mode_nxt = spct_pkg::MODE_RC;
      2'b10:   mode_nxt = spct_pkg::MODE_RC;
      2'b11:   mode_nxt = spct_pkg::MODE_CC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      absx_r  <= absx_nxt;
      absy_r  <= absy_nxt;
      mode1_r <= mode_nxt;
      wsum_r  <= wsum_nxt;
      hsum_r  <= hsum_nxt;
      rsum_r  <= rsum_nxt;
      rw_r    <= rw_nxt;
      rh_r    <= rh_nxt;
      r_r     <= r_nxt;
    end
  end

  // ---------------- Stage 2: interval compares, operand select ----------------
  logic [spct_pkg::ABS_W:0]           twox, twoy;
  logic signed [spct_pkg::DIFF_W-1:0] d_gap, e_gap, r2s;
  spct_pkg::ctl_t                     ctl2_nxt, ctl2_r;
  spct_pkg::sq_ops_t                  ops2_nxt, ops2_r;

  always_comb begin
    twox  = {absx_r, 1'b0};
    twoy  = {absy_r, 1'b0};
    d_gap = $signed({1'b0, twox}) - $signed({4'b0, rw_r});
    e_gap = $signed({1'b0, twoy}) - $signed({4'b0, rh_r});
    r2s   = $signed({3'b0, r_r, 1'b0});

    ctl2_nxt.mode     = mode1_r;
    ctl2_nxt.rr_hit   = (twox < {2'b0, wsum_r}) && (twoy < {2'b0, hsum_r});
    ctl2_nxt.rc_miss  = (d_gap > r2s) || (e_gap > r2s);
    ctl2_nxt.rc_early = (d_gap <= 0) || (e_gap <= 0);

    // Circles square the center distance; mixed pairs square the corner gap
    if (mode1_r == spct_pkg::MODE_CC) begin
      ops2_nxt.a = absx_r;
      ops2_nxt.b = absy_r;
      ops2_nxt.c = {1'b0, rsum_r};
    end else begin
      ops2_nxt.a = d_gap[spct_pkg::ABS_W-1:0];
      ops2_nxt.b = e_gap[spct_pkg::ABS_W-1:0];
      ops2_nxt.c = {1'b0, r_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ctl2_r <= ctl2_nxt;
      ops2_r <= ops2_nxt;
    end
  end

  // ---------------- Stage 3: squares ----------------
  logic [spct_pkg::SQ_W-1:0] sq_a, sq_b, sq_c;
  spct_pkg::ctl_t            ctl3;

  spct_sq u_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en3),
    .valid_i (v2_r),
    .ops_i   (ops2_r),
    .ctl_i   (ctl2_r),
    .valid_o (v3),
    .sq_a_o  (sq_a),
    .sq_b_o  (sq_b),
    .sq_c_o  (sq_c),
    .ctl_o   (ctl3)
  );

  // ---------------- Stage 4: sum, compare, result register ----------------
  logic [spct_pkg::ACC_W-1:0] sq_sum;
  logic                       hit_nxt, hit_r;

  always_comb begin
    sq_sum = {1'b0, sq_a} + {1'b0, sq_b};
    unique case (ctl3.mode)
      spct_pkg::MODE_RR: hit_nxt = ctl3.rr_hit;
      spct_pkg::MODE_CC: hit_nxt = sq_sum < {1'b0, sq_c};
      spct_pkg::MODE_RC: hit_nxt = !ctl3.rc_miss &&
                                   (ctl3.rc_early || (sq_sum <= {1'b0, sq_c}));
      default:           hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {7'b0, hit_r};

endmodule

`default_nettype wire

FILE: tb/spct_overlap_checker.sv
// Checker for the shape pair collision test: watches both stream channels,
// predicts the overlap bit of each accepted pair and compares it in order.
// Depends on spct_pkg for the pair kind enum and the field widths.
`timescale 1ns / 1ps
`default_nettype none

module spct_overlap_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, lowest bit up: a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, zero pad
  input  wire logic [191:0] in_tdata,
  // in_tuser, lowest bit up: a_is_circle, b_is_circle
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  // out_tdata, lowest bit up: hit, zero pad
  input  wire logic [7:0]   out_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  output int                mismatches,
  output int                outstanding
);

  // Overlap bits still owed by the block, oldest first
  logic pending_hits[$];
  int   err_cnt = 0;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Strict interval overlap on both axes, doubled to avoid halving
  function automatic bit rect_pair_hit(input longint dx, input longint dy,
                                       input longint w1, input longint h1,
                                       input longint w2, input longint h2);
    return (2 * mag(dx) < w1 + w2) && (2 * mag(dy) < h1 + h2);
  endfunction

  function automatic bit circle_pair_hit(input longint dx, input longint dy,
                                         input longint r1, input longint r2);
    longint rsum;
    rsum = r1 + r2;
    return (dx * dx + dy * dy) < (rsum * rsum);
  endfunction

  // Clamped corner test, all distances doubled; bounds are inclusive
  function automatic bit rect_circle_hit(input longint dx, input longint dy,
                                         input longint w, input longint h,
                                         input longint r);
    longint gap_x, gap_y, diam;
    gap_x = 2 * mag(dx) - w;
    gap_y = 2 * mag(dy) - h;
    diam  = 2 * r;
    if (gap_x > diam || gap_y > diam) return 1'b0;
    if (gap_x <= 0 || gap_y <= 0) return 1'b1;
    return (gap_x * gap_x + gap_y * gap_y) <= (diam * diam);
  endfunction

  function automatic logic predict_hit(input logic [191:0] d, input logic [1:0] u);
    logic signed [spct_pkg::POS_W-1:0] ax, ay, bx, by;
    longint aw, ah, bw, bh, dx, dy;
    spct_pkg::mode_t pair_kind;
    ax = d[23:0];
    ay = d[47:24];
    aw = longint'(d[70:48]);
    ah = longint'(d[93:71]);
    bx = d[117:94];
    by = d[141:118];
    bw = longint'(d[164:142]);
    bh = longint'(d[187:165]);
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    if (u[0] && u[1]) pair_kind = spct_pkg::MODE_CC;
    else if (u[0] || u[1]) pair_kind = spct_pkg::MODE_RC;
    else pair_kind = spct_pkg::MODE_RR;
    unique case (pair_kind)
      spct_pkg::MODE_RR: return rect_pair_hit(dx, dy, aw, ah, bw, bh);
      // the rectangle may be either object; a circle's height is ignored
      spct_pkg::MODE_RC: return u[1] ? rect_circle_hit(dx, dy, aw, ah, bw)
                                     : rect_circle_hit(dx, dy, bw, bh, aw);
      default: return circle_pair_hit(dx, dy, aw, bw);
    endcase
  endfunction

  // Retire results before queuing new pairs so a stray result is never masked
  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      pending_hits.delete();
      err_cnt = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_hits.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result transfer with none expected, hit=%0b",
                     $realtime, out_tdata[0]);
        end else begin
          want = pending_hits.pop_front();
          if (out_tdata[0] !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: hit mismatch, expected %0b actual %0b",
                       $realtime, want, out_tdata[0]);
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_hits.push_back(predict_hit(in_tdata, in_tuser));
    end
    mismatches  <= err_cnt;
    outstanding <= pending_hits.size();
  end

endmodule

`default_nettype wire

FILE: tb/tb_shape_pair_collision_test.sv
// Testbench top for shape_pair_collision_test: drives shape pairs with random
// gaps and output stalls, and gives the verdict from spct_overlap_checker.
// Depends on spct_pkg, shape_pair_collision_test and spct_overlap_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_shape_pair_collision_test;

  localparam logic KIND_RECT = 1'b0;
  localparam logic KIND_CIRC = 1'b1;

  localparam logic signed [spct_pkg::POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [spct_pkg::POS_W-1:0] POS_MIN = 24'sh800000;
  localparam logic [spct_pkg::SIZE_W-1:0]       SIZE_MAX = 23'h7FFFFF;

  localparam int RANDOM_PAIRS = 600;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [191:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;

  int mismatches;
  int outstanding;
  bit no_gaps = 1'b0;

  shape_pair_collision_test uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  spct_overlap_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Output backpressure: random ready/stall phases, mostly short
  int ready_hold = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 9) == 0) ready_hold <= $urandom_range(20, 50);
      else ready_hold <= $urandom_range(0, 4);
    end
  end

  // Idle cycles between input transfers: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One input transfer, then an optional idle gap; called at a rising edge
  task automatic send_shapes(
    input logic ac,
    input logic [spct_pkg::POS_W-1:0] ax, input logic [spct_pkg::POS_W-1:0] ay,
    input logic [spct_pkg::SIZE_W-1:0] aw, input logic [spct_pkg::SIZE_W-1:0] ah,
    input logic bc,
    input logic [spct_pkg::POS_W-1:0] bx, input logic [spct_pkg::POS_W-1:0] by,
    input logic [spct_pkg::SIZE_W-1:0] bw, input logic [spct_pkg::SIZE_W-1:0] bh);
    int gap;
    in_tdata  <= {4'b0, bh, bw, by, bx, ah, aw, ay, ax};
    in_tuser  <= {bc, ac};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random pair: a fifth over the full field ranges, the rest placed close
  // together at a random scale so that hits and near misses both occur
  task automatic send_random_pair();
    int scale, span;
    logic [spct_pkg::POS_W-1:0] ax, ay, bx, by;
    logic [spct_pkg::SIZE_W-1:0] aw, ah, bw, bh;
    ax = spct_pkg::POS_W'($urandom());
    ay = spct_pkg::POS_W'($urandom());
    if ($urandom_range(0, 4) == 0) begin
      bx = spct_pkg::POS_W'($urandom());
      by = spct_pkg::POS_W'($urandom());
      aw = spct_pkg::SIZE_W'($urandom());
      ah = spct_pkg::SIZE_W'($urandom());
      bw = spct_pkg::SIZE_W'($urandom());
      bh = spct_pkg::SIZE_W'($urandom());
    end else begin
      scale = $urandom_range(1, 22);
      span  = 1 << scale;
      aw = spct_pkg::SIZE_W'($urandom_range(0, span - 1));
      ah = spct_pkg::SIZE_W'($urandom_range(0, span - 1));
      bw = spct_pkg::SIZE_W'($urandom_range(0, span - 1));
      bh = spct_pkg::SIZE_W'($urandom_range(0, span - 1));
      bx = ax + spct_pkg::POS_W'($urandom_range(0, 2 * span) - span);
      by = ay + spct_pkg::POS_W'($urandom_range(0, 2 * span) - span);
    end
    send_shapes(1'($urandom_range(0, 1)), ax, ay, aw, ah,
                1'($urandom_range(0, 1)), bx, by, bw, bh);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rectangle pairs: touching edges miss, one step closer hits
    send_shapes(KIND_RECT, 0, 0, 512, 512, KIND_RECT, 512, 0, 512, 512);
    send_shapes(KIND_RECT, 0, 0, 512, 512, KIND_RECT, 511, 0, 512, 512);
    send_shapes(KIND_RECT, 0, 0, 1000, 100, KIND_RECT, 0, -100, 1000, 100);
    send_shapes(KIND_RECT, 7, 7, 0, 0, KIND_RECT, 7, 7, 0, 0);
    send_shapes(KIND_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
                KIND_RECT, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX);
    send_shapes(KIND_RECT, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX,
                KIND_RECT, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX);
    // Circle pairs: zero radii, tangent, overlapping, far extremes
    send_shapes(KIND_CIRC, 0, 0, 0, 0, KIND_CIRC, 0, 0, 0, 0);
    send_shapes(KIND_CIRC, 0, 0, 3, 0, KIND_CIRC, 3, 4, 2, 0);
    send_shapes(KIND_CIRC, 0, 0, 3, 0, KIND_CIRC, 3, 4, 3, 0);
    send_shapes(KIND_CIRC, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
                KIND_CIRC, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX);
    send_shapes(KIND_CIRC, POS_MIN, POS_MAX, SIZE_MAX, 0,
                KIND_CIRC, POS_MIN, POS_MAX, SIZE_MAX, 0);
    // circle height must not count
    send_shapes(KIND_CIRC, 0, 0, 100, SIZE_MAX, KIND_CIRC, 0, 300, 100, SIZE_MAX);
    // Mixed pairs: corner exactly on the circle, just outside, both orders
    send_shapes(KIND_RECT, 0, 0, 0, 0, KIND_CIRC, 3, 4, 5, 0);
    send_shapes(KIND_RECT, 0, 0, 0, 0, KIND_CIRC, 3, 4, 4, 0);
    send_shapes(KIND_CIRC, 3, 4, 5, SIZE_MAX, KIND_RECT, 0, 0, 0, 0);
    send_shapes(KIND_CIRC, 3, 4, 4, SIZE_MAX, KIND_RECT, 0, 0, 0, 0);
    // gap equal to the diameter inside one slab hits, one more misses
    send_shapes(KIND_RECT, 0, 0, 20, 20, KIND_CIRC, 15, 0, 5, 0);
    send_shapes(KIND_RECT, 0, 0, 20, 20, KIND_CIRC, 16, 0, 5, 0);
    send_shapes(KIND_CIRC, 0, 0, 1, 0, KIND_RECT, 0, 0, SIZE_MAX, SIZE_MAX);
    send_shapes(KIND_RECT, 5, 5, 0, 0, KIND_CIRC, 5, 5, 0, 0);
    send_shapes(KIND_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
                KIND_CIRC, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX);
    send_shapes(KIND_CIRC, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX,
                KIND_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX);

    // Random pairs, with stretches of back-to-back transfers
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      send_random_pair();
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every expected result, then a few more cycles
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
